[hdl/body_boundary_clamp_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the body boundary clamp unit
// Shared concurrent assertion forms, clocked on i_clk.
// ---------------------------------------------------------------------------
`ifndef BODY_BOUNDARY_CLAMP_UNIT_ASSERT_SVH
`define BODY_BOUNDARY_CLAMP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked around reset.
`define BBC_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/bbc_pkg.sv]
// ---------------------------------------------------------------------------
// bbc_pkg
// Types, register indexes and helper functions of the boundary clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

    localparam logic [2:0] REG_MIN_X      = 3'd0;
    localparam logic [2:0] REG_MAX_X      = 3'd1;
    localparam logic [2:0] REG_MIN_Y      = 3'd2;
    localparam logic [2:0] REG_MAX_Y      = 3'd3;
    localparam logic [2:0] REG_MIN_Z      = 3'd4;
    localparam logic [2:0] REG_MAX_Z      = 3'd5;
    localparam logic [2:0] REG_FLOOR_SLOP = 3'd6;
    localparam logic [2:0] REG_FLOOR_ONLY = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] KIND_BOX      = 2'd0;
    localparam logic [1:0] KIND_SPHERE   = 2'd1;
    localparam logic [1:0] KIND_CYLINDER = 2'd2;

    localparam int SQRT_STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES          = 4;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_z;
        logic [30:0]        slop;
        logic               floor_only;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         axis;
        logic               frozen;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } t_side;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] ea;
        logic [30:0] eb;
        logic [30:0] ec;
        logic [15:0] abs_a;
        logic [15:0] abs_b;
        logic [15:0] abs_c;
    } t_geom;

    typedef struct packed {
        logic [28:0] x;
        logic [28:0] res;
    } t_sq;

    // Four steps of the digit-by-digit square root, starting at step first.
    function automatic t_sq sqrt_steps(t_sq s, int first);
        t_sq         r;
        logic [30:0] b;
        logic [30:0] trial;
        r = s;
        for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
            b     = 31'(1) << (30 - 2 * (first + k));
            trial = {2'b00, r.res} + b;
            if ({2'b00, r.x} >= trial) begin
                r.x   = 29'({2'b00, r.x} - trial);
                r.res = 29'(({2'b00, r.res} >> 1) + b);
            end else begin
                r.res = r.res >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [36:0] v);
        if (v > $signed(37'h0_7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < $signed(37'h1F_8000_0000)) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

endpackage
`default_nettype wire

[hdl/bbc_if.sv]
// ---------------------------------------------------------------------------
// bbc_if
// Stream and configuration interfaces of the boundary clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface bbc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_index;
    logic [1:0]         body_kind;
    logic               frozen;
    logic signed [31:0] position_along_axis;
    logic signed [31:0] velocity_along_axis;
    logic [30:0]        extent_a;
    logic [30:0]        extent_b;
    logic [30:0]        extent_c;
    logic signed [15:0] axis_comp_a;
    logic signed [15:0] axis_comp_b;
    logic signed [15:0] axis_comp_c;
    modport source (output valid, axis_index, body_kind, frozen, position_along_axis,
                    velocity_along_axis, extent_a, extent_b, extent_c, axis_comp_a,
                    axis_comp_b, axis_comp_c, input ready);
    modport sink (input valid, axis_index, body_kind, frozen, position_along_axis,
                  velocity_along_axis, extent_a, extent_b, extent_c, axis_comp_a,
                  axis_comp_b, axis_comp_c, output ready);
endinterface

interface bbc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic               wake_body;
    modport source (output valid, new_position, new_velocity, wake_body, input ready);
    modport sink (input valid, new_position, new_velocity, wake_body, output ready);
endinterface

interface bbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/body_boundary_clamp_unit.sv]
// ---------------------------------------------------------------------------
// body_boundary_clamp_unit
// Support extent of a body along one world axis, then bounds clamp.
// ---------------------------------------------------------------------------
// Channel    Dir  Beat contents
// i_item     in   axis, shape, frozen flag, position, velocity, extents, axes
// o_result   out  clamped position, velocity, wake flag
// i_cfg      in   register index and write data, always ready
//
// One beat is accepted every cycle while the output is not stalled. Each beat
// passes through nine pipeline stages: one front stage, four square root
// stages of four steps each, two extent stages and two clamp stages. A
// stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous; it clears the valid bits and restores the register
// defaults, while the data registers are left as they are.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module body_boundary_clamp_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bbc_in_if.sink    i_item,
    bbc_out_if.source o_result,
    bbc_cfg_if.sink   i_cfg
);
    import bbc_pkg::*;

    t_cfg        r_cfg;
    logic        en;

    logic        vld   [SQRT_STAGES+1];
    t_side       side  [SQRT_STAGES+1];
    t_geom       geom  [SQRT_STAGES+1];
    t_sq         sq    [SQRT_STAGES+1];

    logic        ext_vld;
    t_side       ext_side;
    logic [33:0] ext;

    // The pipeline advances whenever the output register is free or drained.
    assign en           = !o_result.valid || o_result.ready;
    assign i_item.ready = en;
    assign i_cfg.ready  = 1'b1;

    // Configuration registers; the user must write them only while the pipeline is idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x      <= -32'sd6553600;
            r_cfg.max_x      <= 32'sd6553600;
            r_cfg.min_y      <= 32'sd0;
            r_cfg.max_y      <= 32'sd6553600;
            r_cfg.min_z      <= -32'sd6553600;
            r_cfg.max_z      <= 32'sd6553600;
            r_cfg.slop       <= 31'd0;
            r_cfg.floor_only <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_X:      r_cfg.min_x      <= i_cfg.data;
                REG_MAX_X:      r_cfg.max_x      <= i_cfg.data;
                REG_MIN_Y:      r_cfg.min_y      <= i_cfg.data;
                REG_MAX_Y:      r_cfg.max_y      <= i_cfg.data;
                REG_MIN_Z:      r_cfg.min_z      <= i_cfg.data;
                REG_MAX_Z:      r_cfg.max_z      <= i_cfg.data;
                REG_FLOOR_SLOP: r_cfg.slop       <= i_cfg.data[30:0];
                REG_FLOOR_ONLY: r_cfg.floor_only <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Front stage: absolute axis components and the radial remainder.
    bbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_item.valid),
        .i_axis   (i_item.axis_index),
        .i_kind   (i_item.body_kind),
        .i_frozen (i_item.frozen),
        .i_pos    (i_item.position_along_axis),
        .i_vel    (i_item.velocity_along_axis),
        .i_ea     (i_item.extent_a),
        .i_eb     (i_item.extent_b),
        .i_ec     (i_item.extent_c),
        .i_ca     (i_item.axis_comp_a),
        .i_cb     (i_item.axis_comp_b),
        .i_cc     (i_item.axis_comp_c),
        .o_vld    (vld[0]),
        .o_side   (side[0]),
        .o_geom   (geom[0]),
        .o_sq     (sq[0])
    );

    // Square root of the radial remainder, four steps per stage.
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        bbc_sqrt_stage #(
            .FIRST_STEP (g * SQRT_STEPS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[g]),
            .i_side  (side[g]),
            .i_geom  (geom[g]),
            .i_sq    (sq[g]),
            .o_vld   (vld[g+1]),
            .o_side  (side[g+1]),
            .o_geom  (geom[g+1]),
            .o_sq    (sq[g+1])
        );
    end

    // The radial factor never exceeds one in Q2.14, so fifteen bits hold it.
    bbc_extent u_extent (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (vld[SQRT_STAGES]),
        .i_side   (side[SQRT_STAGES]),
        .i_geom   (geom[SQRT_STAGES]),
        .i_radial (sq[SQRT_STAGES].res[14:0]),
        .o_vld    (ext_vld),
        .o_side   (ext_side),
        .o_ext    (ext)
    );

    bbc_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (ext_vld),
        .i_side  (ext_side),
        .i_ext   (ext),
        .i_cfg   (r_cfg),
        .o_vld   (o_result.valid),
        .o_pos   (o_result.new_position),
        .o_vel   (o_result.new_velocity),
        .o_wake  (o_result.wake_body)
    );
endmodule
`default_nettype wire

[hdl/bbc_front.sv]
// ---------------------------------------------------------------------------
// bbc_front
// First stage: absolute components and the cylinder radial remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bbc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic [1:0]         i_axis,
    input  wire logic [1:0]         i_kind,
    input  wire logic               i_frozen,
    input  wire logic signed [31:0] i_pos,
    input  wire logic signed [31:0] i_vel,
    input  wire logic [30:0]        i_ea,
    input  wire logic [30:0]        i_eb,
    input  wire logic [30:0]        i_ec,
    input  wire logic signed [15:0] i_ca,
    input  wire logic signed [15:0] i_cb,
    input  wire logic signed [15:0] i_cc,
    output logic                    o_vld,
    output bbc_pkg::t_side          o_side,
    output bbc_pkg::t_geom          o_geom,
    output bbc_pkg::t_sq            o_sq
);
    import bbc_pkg::*;

    logic               r_vld;
    t_side              r_side, n_side;
    t_geom              r_geom, n_geom;
    t_sq                r_sq, n_sq;
    logic signed [31:0] sq_a;
    logic signed [31:0] rem;

    always_comb begin
        n_side = '{axis: i_axis, frozen: i_frozen, pos: i_pos, vel: i_vel};
        n_geom.kind  = i_kind;
        n_geom.ea    = i_ea;
        n_geom.eb    = i_eb;
        n_geom.ec    = i_ec;
        n_geom.abs_a = i_ca[15] ? (~i_ca + 16'd1) : i_ca;
        n_geom.abs_b = i_cb[15] ? (~i_cb + 16'd1) : i_cb;
        n_geom.abs_c = i_cc[15] ? (~i_cc + 16'd1) : i_cc;
        sq_a = 32'(i_ca) * 32'(i_ca);
        rem  = 32'sh1000_0000 - sq_a;
        // An axle longer than unit length gives no radial reach.
        n_sq.x   = (rem > 32'sd0) ? rem[28:0] : 29'd0;
        n_sq.res = 29'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_geom <= n_geom;
            r_sq   <= n_sq;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_geom = r_geom;
    assign o_sq   = r_sq;
endmodule
`default_nettype wire

[hdl/bbc_sqrt_stage.sv]
// ---------------------------------------------------------------------------
// bbc_sqrt_stage
// One registered slice of the pipelined integer square root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bbc_sqrt_stage #(
    parameter int FIRST_STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire bbc_pkg::t_side i_side,
    input  wire bbc_pkg::t_geom i_geom,
    input  wire bbc_pkg::t_sq   i_sq,
    output logic                o_vld,
    output bbc_pkg::t_side      o_side,
    output bbc_pkg::t_geom      o_geom,
    output bbc_pkg::t_sq        o_sq
);
    import bbc_pkg::*;

    logic  r_vld;
    t_side r_side;
    t_geom r_geom;
    t_sq   r_sq, n_sq;

    always_comb begin
        n_sq = sqrt_steps(i_sq, FIRST_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_geom <= i_geom;
            r_sq   <= n_sq;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_geom = r_geom;
    assign o_sq   = r_sq;
endmodule
`default_nettype wire

[hdl/bbc_extent.sv]
// ---------------------------------------------------------------------------
// bbc_extent
// Two stages: shape products, then rounded sum into the support extent (a sphere passes extent a).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bbc_extent (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire bbc_pkg::t_side i_side,
    input  wire bbc_pkg::t_geom i_geom,
    input  wire logic [14:0]    i_radial,
    output logic                o_vld,
    output bbc_pkg::t_side      o_side,
    output logic [33:0]         o_ext
);
    import bbc_pkg::*;

    logic        r_vld1, r_vld2;
    t_side       r_side1, r_side2;
    logic [1:0]  r_kind;
    logic [30:0] r_ea;
    logic [46:0] r_p0, r_p1, r_p2, n_p0, n_p1, n_p2;
    logic [48:0] sum;
    logic [33:0] r_ext, n_ext;

    always_comb begin
        case (i_geom.kind)
            KIND_CYLINDER: begin
                n_p0 = 47'(i_geom.ea) * 47'(i_radial);
                n_p1 = 47'(i_geom.eb) * 47'(i_geom.abs_a);
                n_p2 = 47'd0;
            end
            default: begin
                n_p0 = 47'(i_geom.ea) * 47'(i_geom.abs_a);
                n_p1 = 47'(i_geom.eb) * 47'(i_geom.abs_b);
                n_p2 = 47'(i_geom.ec) * 47'(i_geom.abs_c);
            end
        endcase
    end

    always_comb begin
        sum   = 49'(r_p0) + 49'(r_p1) + 49'(r_p2) + 49'd8192;
        n_ext = (r_kind == KIND_SPHERE) ? 34'(r_ea) : sum[47:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_kind  <= i_geom.kind;
            r_ea    <= i_geom.ea;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_side2 <= r_side1;
            r_ext   <= n_ext;
        end
    end

    assign o_vld  = r_vld2;
    assign o_side = r_side2;
    assign o_ext  = r_ext;
endmodule
`default_nettype wire

[hdl/bbc_clamp.sv]
// ---------------------------------------------------------------------------
// bbc_clamp
// Two stages: minimum clamp, then maximum clamp on the updated position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bbc_clamp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire bbc_pkg::t_side i_side,
    input  wire logic [33:0]    i_ext,
    input  wire bbc_pkg::t_cfg  i_cfg,
    output logic                o_vld,
    output logic signed [31:0]  o_pos,
    output logic signed [31:0]  o_vel,
    output logic                o_wake
);
    import bbc_pkg::*;

    logic               r_vld1, r_vld2;
    logic               r_act;
    logic [1:0]         r_axis;
    logic [33:0]         r_ext;
    logic signed [31:0] r_pos1, r_vel1, n_pos1, n_vel1;
    logic               r_wake1, n_wake1;
    logic signed [31:0] r_pos2, r_vel2, n_pos2, n_vel2;
    logic               r_wake2, n_wake2;
    logic               act;
    logic signed [31:0] lo, hi;
    logic signed [36:0] s_ext, thr, s_ext2;

    always_comb begin
        act = !i_side.frozen && (i_side.axis != 2'd3)
              && (!i_cfg.floor_only || (i_side.axis == AXIS_Y));
        case (i_side.axis)
            AXIS_X:  lo = i_cfg.min_x;
            AXIS_Y:  lo = i_cfg.min_y;
            default: lo = i_cfg.min_z;
        endcase
        s_ext = $signed({3'b000, i_ext});
        thr   = (i_side.axis == AXIS_Y) ? (37'(lo) - $signed({6'd0, i_cfg.slop})) : 37'(lo);
        n_pos1  = i_side.pos;
        n_vel1  = i_side.vel;
        n_wake1 = 1'b0;
        if (act && ((37'(i_side.pos) - s_ext) < thr)) begin
            n_pos1  = sat32(37'(lo) + s_ext);
            n_wake1 = 1'b1;
            if (i_side.vel < 0) begin
                n_vel1 = 32'sd0;
            end
        end
    end

    always_comb begin
        case (r_axis)
            AXIS_X:  hi = i_cfg.max_x;
            AXIS_Y:  hi = i_cfg.max_y;
            default: hi = i_cfg.max_z;
        endcase
        s_ext2  = $signed({3'b000, r_ext});
        n_pos2  = r_pos1;
        n_vel2  = r_vel1;
        n_wake2 = r_wake1;
        if (r_act && !i_cfg.floor_only && ((37'(r_pos1) + s_ext2) > 37'(hi))) begin
            n_pos2  = sat32(37'(hi) - s_ext2);
            n_wake2 = 1'b1;
            if (r_vel1 > 0) begin
                n_vel2 = 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act   <= act;
            r_axis  <= i_side.axis;
            r_ext   <= i_ext;
            r_pos1  <= n_pos1;
            r_vel1  <= n_vel1;
            r_wake1 <= n_wake1;
            r_pos2  <= n_pos2;
            r_vel2  <= n_vel2;
            r_wake2 <= n_wake2;
        end
    end

    assign o_vld  = r_vld2;
    assign o_pos  = r_pos2;
    assign o_vel  = r_vel2;
    assign o_wake = r_wake2;
endmodule
`default_nettype wire

[hdl/bbc_checker.sv]
// ---------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the boundary clamp unit, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "body_boundary_clamp_unit_assert.svh"
module bbc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_pos,
    input wire logic [31:0] i_out_vel
);
    `BBC_ASSERT_SAME(a_ready_follows_out, 1'b1, i_in_ready == (!i_out_valid || i_out_ready))
    `BBC_ASSERT_ALWAYS(a_empty_after_reset, !$past(i_rst_n), !i_out_valid)
    `BBC_ASSERT_NEXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid)
    `BBC_ASSERT_NEXT(a_data_holds, i_out_valid && !i_out_ready, $stable(i_out_pos) && $stable(i_out_vel))
endmodule

bind body_boundary_clamp_unit bbc_checker u_bbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_pos   (o_result.new_position),
    .i_out_vel   (o_result.new_velocity)
);
`default_nettype wire
